@@ src/tlbpt_pkg.sv @@
// Package for the TLB / page-table translator.
// Holds address field widths, table sizes and the controller state type.
// No dependencies.
package tlbpt_pkg;

   // address split: page number over byte offset
   localparam int unsigned ADDR_BITS   = 16;
   localparam int unsigned PAGE_BITS   = 8;
   localparam int unsigned OFFSET_BITS = 8;
   localparam int unsigned FRAME_BITS  = 8;

   localparam int unsigned PAGE_COUNT  = 1 << PAGE_BITS;
   localparam int unsigned PAGE_BYTES  = 1 << OFFSET_BITS;
   localparam int unsigned FRAME_COUNT = 1 << FRAME_BITS;

   // default TLB size
   localparam int unsigned TLB_ENTRIES_DEF = 16;

   typedef logic [ADDR_BITS-1:0]   addr_type;
   typedef logic [PAGE_BITS-1:0]   page_type;
   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [FRAME_BITS-1:0]  frame_type;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

@@ src/tlbpt_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and only updates on a read enable.
// No dependencies.
module tlbpt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/tlb_page_table_translator_unit.sv @@
// TLB and page-table address translator with demand paging. Each request is a
// 16-bit virtual address (page in bits 15..8, offset in bits 7..0); each gives
// one response with the physical address, a TLB hit flag and a page-fault flag.
// For each request, the page-table RAM is read on the cycle the
// request is taken, and in the following cycle the TLB is compared in parallel,
// the read frame is used and any new page-table entry is written back. The
// input stalls during that lookup cycle, which orders every RAM write ahead of
// the next read. Responses wait in an output register, so a stalled response
// holds the lookup for as long as the response side stalls; the next request
// is taken as soon as the lookup has moved into that register. Page-present
// bits clear at reset; there is no clearing pass. Frames are handed out from 0
// upward and wrap after the last frame, and the TLB refills oldest-first.
// Depends on tlbpt_pkg and tlbpt_ram.
module tlb_page_table_translator_unit #(
   parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tlbpt_pkg::addr_type      req_virtual_address,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tlbpt_pkg::addr_type      rsp_physical_address,
   output logic                     rsp_tlb_hit,
   output logic                     rsp_page_fault
);

   import tlbpt_pkg::*;

   localparam int unsigned SLOT_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int unsigned CNT_W  = $clog2(TLB_ENTRIES + 1);

   // controller
   state_type state_ff, state_in;
   logic      ram_rd_en;
   logic      out_free;
   logic      lookup_done;

   // request held through the lookup
   page_type   page_ff, page_in;
   offset_type offset_ff, offset_in;

   // TLB storage and fill state
   page_type          tlb_tag_ff   [TLB_ENTRIES];
   frame_type         tlb_frame_ff [TLB_ENTRIES];
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [SLOT_W-1:0] oldest_ff, oldest_in;

   // page table state
   logic [PAGE_COUNT-1:0] present_ff, present_in;
   frame_type             next_free_ff, next_free_in;
   frame_type             pt_rd_frame;

   // lookup datapath
   logic              tlb_found;
   frame_type         tlb_found_frame;
   logic              fault;
   frame_type         frame_sel;
   logic              tlb_full;
   logic [SLOT_W-1:0] ins_slot;
   logic              pt_wr_en;

   // response register
   logic     rsp_valid_ff, rsp_valid_in;
   addr_type rsp_addr_ff;
   logic     rsp_hit_ff;
   logic     rsp_fault_ff;

   // page-table frame store
   tlbpt_ram #(
      .WIDTH (FRAME_BITS),
      .DEPTH (PAGE_COUNT)
   ) u_page_frame_ram (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (page_ff),
      .wr_data (next_free_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (req_virtual_address[ADDR_BITS-1:OFFSET_BITS]),
      .rd_data (pt_rd_frame)
   );

   // response register can take a new result
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_stall   = 1'b1;
      ram_rd_en   = 1'b0;
      lookup_done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            ram_rd_en = req_valid;
         end
         ST_LOOKUP: begin
            lookup_done = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // capture the request
   always_comb begin
      page_in   = page_ff;
      offset_in = offset_ff;
      if (ram_rd_en) begin
         page_in   = req_virtual_address[ADDR_BITS-1:OFFSET_BITS];
         offset_in = req_virtual_address[OFFSET_BITS-1:0];
      end
   end

   // parallel TLB compare, lowest filled slot wins
   always_comb begin
      tlb_found       = 1'b0;
      tlb_found_frame = '0;
      for (int i = 0; i < int'(TLB_ENTRIES); i++) begin
         if (!tlb_found && (CNT_W'(i) < fill_ff) && (tlb_tag_ff[i] == page_ff)) begin
            tlb_found       = 1'b1;
            tlb_found_frame = tlb_frame_ff[i];
         end
      end
   end

   // frame selection and fault detection
   always_comb begin
      fault     = !tlb_found && !present_ff[page_ff];
      frame_sel = pt_rd_frame;
      priority if (tlb_found) begin
         frame_sel = tlb_found_frame;
      end else if (fault) begin
         frame_sel = next_free_ff;
      end else begin
         frame_sel = pt_rd_frame;
      end
   end

   assign pt_wr_en = lookup_done && fault;

   // FIFO slot choice for a TLB refill
   assign tlb_full = (fill_ff == CNT_W'(TLB_ENTRIES));
   assign ins_slot = tlb_full ? oldest_ff : fill_ff[SLOT_W-1:0];

   // fill state, present bits and free-frame counter
   always_comb begin
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      present_in   = present_ff;
      next_free_in = next_free_ff;
      if (lookup_done && !tlb_found) begin
         if (tlb_full) begin
            oldest_in = (oldest_ff == SLOT_W'(TLB_ENTRIES - 1)) ? '0 : oldest_ff + 1'b1;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (pt_wr_en) begin
         present_in[page_ff] = 1'b1;
         next_free_in = (next_free_ff == FRAME_BITS'(FRAME_COUNT - 1)) ?
                        '0 : next_free_ff + 1'b1;
      end
   end

   // response handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (lookup_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         present_ff   <= '0;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         present_ff   <= present_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      page_ff   <= page_in;
      offset_ff <= offset_in;
      if (lookup_done) begin
         rsp_addr_ff  <= {frame_sel, offset_ff};
         rsp_hit_ff   <= tlb_found;
         rsp_fault_ff <= fault;
      end
      if (lookup_done && !tlb_found) begin
         tlb_tag_ff[ins_slot]   <= page_ff;
         tlb_frame_ff[ins_slot] <= frame_sel;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_addr_ff;
   assign rsp_tlb_hit          = rsp_hit_ff;
   assign rsp_page_fault       = rsp_fault_ff;

   // a taken request always moves into the lookup cycle
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_LOOKUP))
      else $error("request taken but no lookup followed");

   // a new response only comes out of a lookup
   a_rsp_from_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOKUP))
      else $error("response raised without a lookup");

   // a TLB hit never reports a fault
   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_fault_ff))
      else $error("response flags both hit and fault");

   // fill count never passes the TLB size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(TLB_ENTRIES))
      else $error("TLB fill count out of range");

endmodule

@@ bench/tb_tlb_page_table_translator_unit.sv @@
`timescale 1ns / 100ps
// Self-checking bench for tlb_page_table_translator_unit: directed and random address
// requests, each checked against an in-bench model of the TLB and the page table.
// Depends on tlbpt_pkg and the translator RTL.
module tb_tlb_page_table_translator_unit;
   import tlbpt_pkg::*;

   localparam int TLB_SLOTS       = TLB_ENTRIES_DEF;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int SETTLE_CYCLES   = 10;
   localparam int REPORT_LIMIT    = 10;
   localparam int RANDOM_REQUESTS = 1560;
   localparam int IDLE_PERCENT    = 20;

   typedef struct packed {
      addr_type virtual_address;
      addr_type physical_address;
      logic     tlb_hit;
      logic     page_fault;
   } translation_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   addr_type req_virtual_address = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   addr_type rsp_physical_address;
   logic     rsp_tlb_hit;
   logic     rsp_page_fault;

   // translation state mirrored in the bench
   page_type  tlb_pages [TLB_SLOTS];
   frame_type tlb_frames [TLB_SLOTS];
   int        tlb_used;
   int        tlb_victim;
   logic      page_mapped [PAGE_COUNT];
   frame_type page_frames [PAGE_COUNT];
   int        next_frame;

   translation_type pending_translations [$];
   int mismatch_count = 0;
   int response_count = 0;
   int cycle_count = 0;
   int hold_off_left = 0;
   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;
   bit hold_off_toggle = 1'b0;
   bit hold_off_seen = 1'b0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tlb_page_table_translator_unit #(
      .TLB_ENTRIES(TLB_SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_virtual_address(req_virtual_address),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_physical_address(rsp_physical_address),
      .rsp_tlb_hit(rsp_tlb_hit),
      .rsp_page_fault(rsp_page_fault)
   );

   // translate one address and update the mirrored tables
   function automatic translation_type translate_address(input addr_type va);
      translation_type result;
      page_type        page;
      offset_type      offset;
      frame_type       frame;
      logic            hit;
      logic            fault;
      int              slot;
      int              i;
      page   = va[ADDR_BITS-1:OFFSET_BITS];
      offset = va[OFFSET_BITS-1:0];
      frame  = '0;
      hit    = 1'b0;
      fault  = 1'b0;
      // only filled slots take part in the search
      for (i = 0; i < tlb_used; i++) begin
         if (!hit && tlb_pages[i] == page) begin
            hit   = 1'b1;
            frame = tlb_frames[i];
         end
      end
      if (!hit) begin
         // demand paging: next free frame, wrapping after the last one
         if (!page_mapped[page]) begin
            fault             = 1'b1;
            page_frames[page] = frame_type'(next_frame);
            page_mapped[page] = 1'b1;
            next_frame        = (next_frame + 1 >= FRAME_COUNT) ? 0 : next_frame + 1;
         end
         frame = page_frames[page];
         // fill in order, then replace oldest first
         if (tlb_used < TLB_SLOTS) begin
            slot = tlb_used;
            tlb_used++;
         end else begin
            slot       = tlb_victim;
            tlb_victim = (tlb_victim + 1) % TLB_SLOTS;
         end
         tlb_pages[slot]  = page;
         tlb_frames[slot] = frame;
      end
      result.virtual_address  = va;
      result.physical_address = addr_type'(frame * PAGE_BYTES + offset);
      result.tlb_hit          = hit;
      result.page_fault       = fault;
      return result;
   endfunction

   // offer one request, with an occasional idle gap first
   task automatic send_address(input addr_type va);
      if (!sender_calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_virtual_address <= va;
      do
         @(posedge clock);
      while (req_stall);
      pending_translations.push_back(translate_address(va));
   endtask

   // stop offering and wait until every response is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_translations.size() != 0)
         @(posedge clock);
   endtask

   // response stall: random, or held for a long stretch when asked
   always @(posedge clock) begin
      if (hold_off_toggle != hold_off_seen) begin
         hold_off_seen = hold_off_toggle;
         hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !receiver_calm && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin : response_check
      translation_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         response_count++;
         if (pending_translations.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("response %0d with nothing outstanding: pa %h hit %b fault %b",
                        response_count, rsp_physical_address, rsp_tlb_hit, rsp_page_fault);
         end else begin
            want = pending_translations.pop_front();
            if (rsp_physical_address !== want.physical_address ||
                rsp_tlb_hit !== want.tlb_hit || rsp_page_fault !== want.page_fault) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display(
                     "response %0d va %h: expected pa %h hit %b fault %b, got pa %h hit %b fault %b",
                     response_count, want.virtual_address, want.physical_address,
                     want.tlb_hit, want.page_fault, rsp_physical_address,
                     rsp_tlb_hit, rsp_page_fault);
            end
         end
      end
   end

   // lowest and highest pages and offsets, first touch then reuse
   task automatic test_address_extremes();
      addr_type corners [6] = '{16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'h8000, 16'h7FFF};
      foreach (corners[i])
         send_address(corners[i]);
   endtask

   // overflow the TLB so the oldest slots are replaced
   task automatic test_tlb_fifo_refill();
      int n;
      for (n = 0; n <= TLB_SLOTS; n++)
         send_address({page_type'(8'h10 + n), offset_type'($urandom)});
      // page 0 has been evicted but stays mapped: a miss without a fault
      send_address(16'h0012);
      // most recent page is still cached
      send_address({page_type'(8'h10 + TLB_SLOTS), 8'h34});
   endtask

   // touch every page in shuffled order so the frame counter runs out and wraps
   task automatic test_frame_exhaustion();
      page_type order [PAGE_COUNT];
      page_type swap_page;
      int       n;
      int       k;
      foreach (order[i])
         order[i] = page_type'(i);
      for (n = PAGE_COUNT - 1; n > 0; n--) begin
         k         = $urandom_range(n, 0);
         swap_page = order[n];
         order[n]  = order[k];
         order[k]  = swap_page;
      end
      foreach (order[i])
         send_address({order[i], offset_type'($urandom)});
   endtask

   // response side holds off while requests keep coming
   task automatic test_output_hold_off();
      int n;
      sender_calm     = 1'b1;
      hold_off_toggle = !hold_off_toggle;
      for (n = 0; n < 40; n++)
         send_address({page_type'($urandom_range(0, 7)), offset_type'($urandom)});
      sender_calm = 1'b0;
   endtask

   // request side pauses until every response is back
   task automatic test_drain_pause();
      int n;
      for (n = 0; n < 10; n++)
         send_address(addr_type'($urandom));
      wait_for_drain();
      for (n = 0; n < 10; n++)
         send_address(addr_type'($urandom));
   endtask

   // working sets that move around, mixed with scattered pages
   task automatic test_random_traffic();
      page_type base;
      page_type page;
      int       span;
      int       n;
      base = '0;
      span = 1;
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 64 == 0) begin
            base = page_type'($urandom);
            span = $urandom_range(4, 24);
         end
         // one stretch with no idling on either side
         sender_calm   = (n >= 600 && n < 900);
         receiver_calm = sender_calm;
         if ($urandom_range(0, 99) < 75)
            page = base + page_type'($urandom_range(0, span - 1));
         else
            page = page_type'($urandom);
         send_address({page, offset_type'($urandom)});
      end
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;
   endtask

   initial begin : stimulus
      tlb_used   = 0;
      tlb_victim = 0;
      next_frame = 0;
      foreach (page_mapped[i])
         page_mapped[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_address_extremes();
      test_tlb_fifo_refill();
      test_frame_exhaustion();
      test_output_hold_off();
      test_drain_pause();
      test_random_traffic();
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_translations.size() == 0)
         $display("tb_tlb_page_table_translator_unit OK");
      else
         $display("tb_tlb_page_table_translator_unit NOT OK");
      $finish;
   end

   // run limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_tlb_page_table_translator_unit NOT OK");
      $finish;
   end

endmodule

@@ tlb_page_table_translator_unit.f @@
src/tlbpt_pkg.sv
src/tlbpt_ram.sv
src/tlb_page_table_translator_unit.sv
bench/tb_tlb_page_table_translator_unit.sv
